/* rtl/bth_pkg.sv */
package bth_pkg;

  localparam int HEAP_CAPACITY = 16;
  localparam int RESULT_LIMIT  = 16;
  localparam int LIM_CAP       = (HEAP_CAPACITY < RESULT_LIMIT) ? HEAP_CAPACITY : RESULT_LIMIT;
  localparam int IDX_W         = $clog2(HEAP_CAPACITY);
  localparam int CNT_W         = $clog2(HEAP_CAPACITY + 1);
  localparam int CHILD_W       = IDX_W + 2;
  localparam int LIM_W         = 5;
  localparam int CMP_W         = (CNT_W > LIM_W) ? CNT_W : LIM_W;
  localparam int SCORE_W       = 32;
  localparam int SRC_W         = 4;
  localparam int ACT_W         = 16;
  localparam logic [LIM_W-1:0] LIM_RESET = LIM_W'(16);

  localparam logic OP_OFFER = 1'b0;
  localparam logic OP_FLUSH = 1'b1;

  typedef struct packed {
    logic signed [SCORE_W-1:0] score;
    logic [SRC_W-1:0]          source;
    logic [ACT_W-1:0]          action;
  } entry_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_UP_RD,
    S_UP_CMP,
    S_RT_RD,
    S_RT_CMP,
    S_DN_RD,
    S_DN_CMP,
    S_FL_RD,
    S_FL_OUT
  } state_t;

  typedef enum logic [2:0] {
    RD_NONE,
    RD_PARENT,
    RD_ROOT,
    RD_CHILD,
    RD_POS
  } rd_sel_t;

  typedef struct packed {
    logic    ld_append;
    logic    ld_replace;
    logic    ld_flush;
    rd_sel_t rd_sel;
    logic    wr_item;
    logic    wr_parent;
    logic    wr_child;
    logic    fl_emit;
  } cmd_t;

  typedef struct packed {
    logic full;
    logic cnt_zero;
    logic pos_zero;
    logic up_less;
    logic root_less;
    logic dn_move;
    logic fl_last;
    logic out_free;
  } sts_t;

endpackage

/* rtl/bth_ifs.sv */
interface bth_in_if import bth_pkg::*; ();
  logic                      valid;
  logic                      ready;
  logic                      op;
  logic signed [SCORE_W-1:0] score;
  logic [SRC_W-1:0]          source_index;
  logic [ACT_W-1:0]          action_tag;

  modport source (output valid, op, score, source_index, action_tag, input ready);
  modport sink   (input valid, op, score, source_index, action_tag, output ready);
endinterface

interface bth_out_if import bth_pkg::*; ();
  logic                      valid;
  logic                      ready;
  logic signed [SCORE_W-1:0] entry_score;
  logic [SRC_W-1:0]          entry_source;
  logic [ACT_W-1:0]          entry_action;
  logic                      entry_valid;
  logic                      last;

  modport source (output valid, entry_score, entry_source, entry_action, entry_valid, last,
                  input ready);
  modport sink   (input valid, entry_score, entry_source, entry_action, entry_valid, last,
                  output ready);
endinterface

/* rtl/bth_ctrl.sv */
module bth_ctrl import bth_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  input  logic in_op,
  input  sts_t sts,
  output logic in_ready,
  output cmd_t cmd
);

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          if (in_op == OP_FLUSH) begin
            state_nxt = S_FL_RD;
          end else if (sts.full) begin
            state_nxt = S_RT_RD;
          end else begin
            state_nxt = S_UP_RD;
          end
        end
      end
      S_UP_RD:  state_nxt = sts.pos_zero ? S_IDLE : S_UP_CMP;
      S_UP_CMP: state_nxt = sts.up_less ? S_UP_RD : S_IDLE;
      S_RT_RD:  state_nxt = S_RT_CMP;
      S_RT_CMP: state_nxt = sts.root_less ? S_DN_RD : S_IDLE;
      S_DN_RD:  state_nxt = S_DN_CMP;
      S_DN_CMP: state_nxt = sts.dn_move ? S_DN_RD : S_IDLE;
      S_FL_RD:  state_nxt = S_FL_OUT;
      S_FL_OUT: begin
        if (sts.out_free) begin
          state_nxt = (sts.cnt_zero || sts.fl_last) ? S_IDLE : S_FL_RD;
        end
      end
      default:  state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    in_ready = 1'b0;
    cmd      = '0;
    cmd.rd_sel = RD_NONE;
    unique case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          if (in_op == OP_FLUSH) begin
            cmd.ld_flush = 1'b1;
          end else if (sts.full) begin
            cmd.ld_replace = 1'b1;
          end else begin
            cmd.ld_append = 1'b1;
          end
        end
      end
      S_UP_RD: begin
        if (sts.pos_zero) begin
          cmd.wr_item = 1'b1;
        end else begin
          cmd.rd_sel = RD_PARENT;
        end
      end
      S_UP_CMP: begin
        if (sts.up_less) begin
          cmd.wr_parent = 1'b1;
        end else begin
          cmd.wr_item = 1'b1;
        end
      end
      S_RT_RD:  cmd.rd_sel = RD_ROOT;
      S_RT_CMP: ;
      S_DN_RD:  cmd.rd_sel = RD_CHILD;
      S_DN_CMP: begin
        if (sts.dn_move) begin
          cmd.wr_child = 1'b1;
        end else begin
          cmd.wr_item = 1'b1;
        end
      end
      S_FL_RD:  cmd.rd_sel = RD_POS;
      S_FL_OUT: cmd.fl_emit = sts.out_free;
      default: ;
    endcase
  end

endmodule

/* rtl/bth_datapath.sv */
module bth_datapath import bth_pkg::*; (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      cfg_we,
  input  logic [LIM_W-1:0]          cfg_wdata,
  input  logic signed [SCORE_W-1:0] in_score,
  input  logic [SRC_W-1:0]          in_source_index,
  input  logic [ACT_W-1:0]          in_action_tag,
  input  cmd_t                      cmd,
  output sts_t                      sts,
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic signed [SCORE_W-1:0] out_entry_score,
  output logic [SRC_W-1:0]          out_entry_source,
  output logic [ACT_W-1:0]          out_entry_action,
  output logic                      out_entry_valid,
  output logic                      out_last
);

  entry_t mem [HEAP_CAPACITY];

  entry_t            item_r, rd_a_r, rd_b_r, out_r;
  logic [IDX_W-1:0]  pos_r;
  logic [CNT_W-1:0]  cnt_r;
  logic [LIM_W-1:0]  lim_r;
  logic              out_valid_r, out_ev_r, out_last_r;

  logic [CMP_W-1:0]   eff_lim;
  logic [IDX_W-1:0]   parent_idx;
  logic [CHILD_W-1:0] l_idx, r_idx;
  logic               l_ok, r_ok, pick_l, pick_r;
  entry_t             best, child;
  logic [IDX_W-1:0]   child_idx;
  logic [IDX_W-1:0]   raddr_a, raddr_b;
  logic               rd_en, we;
  entry_t             wdata;
  entry_t             in_entry;

  assign in_entry = '{score: in_score, source: in_source_index, action: in_action_tag};

  // saturate the limit into 1 .. LIM_CAP
  always_comb begin
    if (lim_r == '0) begin
      eff_lim = CMP_W'(1);
    end else if (CMP_W'(lim_r) > CMP_W'(LIM_CAP)) begin
      eff_lim = CMP_W'(LIM_CAP);
    end else begin
      eff_lim = CMP_W'(lim_r);
    end
  end

  assign parent_idx = IDX_W'((pos_r - IDX_W'(1)) >> 1);
  assign l_idx      = CHILD_W'({pos_r, 1'b0}) + CHILD_W'(1);
  assign r_idx      = l_idx + CHILD_W'(1);
  assign l_ok       = l_idx < CHILD_W'(cnt_r);
  assign r_ok       = r_idx < CHILD_W'(cnt_r);

  // pick the smallest of hole item, left and right; ties keep the earlier one
  assign pick_l    = l_ok && ($signed(rd_a_r.score) < $signed(item_r.score));
  assign best      = pick_l ? rd_a_r : item_r;
  assign pick_r    = r_ok && ($signed(rd_b_r.score) < $signed(best.score));
  assign child     = pick_r ? rd_b_r : rd_a_r;
  assign child_idx = pick_r ? r_idx[IDX_W-1:0] : l_idx[IDX_W-1:0];

  always_comb begin
    raddr_a = pos_r;
    raddr_b = pos_r;
    case (cmd.rd_sel)
      RD_PARENT: raddr_a = parent_idx;
      RD_ROOT:   raddr_a = '0;
      RD_CHILD: begin
        raddr_a = l_idx[IDX_W-1:0];
        raddr_b = r_idx[IDX_W-1:0];
      end
      default: ;
    endcase
  end

  assign rd_en = cmd.rd_sel != RD_NONE;
  assign we    = cmd.wr_item || cmd.wr_parent || cmd.wr_child;

  always_comb begin
    if (cmd.wr_item) begin
      wdata = item_r;
    end else if (cmd.wr_parent) begin
      wdata = rd_a_r;
    end else begin
      wdata = child;
    end
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[pos_r] <= wdata;
    end
    if (rd_en) begin
      rd_a_r <= mem[raddr_a];
      rd_b_r <= mem[raddr_b];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r       <= '0;
      lim_r       <= LIM_RESET;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        lim_r <= cfg_wdata;
      end
      if (cmd.ld_append) begin
        cnt_r <= cnt_r + CNT_W'(1);
      end
      if (cmd.fl_emit) begin
        out_valid_r <= 1'b1;
        if (cnt_r == '0 || sts.fl_last) begin
          cnt_r <= '0;
        end
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.ld_append) begin
      item_r <= in_entry;
      pos_r  <= cnt_r[IDX_W-1:0];
    end
    if (cmd.ld_replace) begin
      item_r <= in_entry;
      pos_r  <= '0;
    end
    if (cmd.ld_flush) begin
      pos_r <= '0;
    end
    if (cmd.wr_parent) begin
      pos_r <= parent_idx;
    end
    if (cmd.wr_child) begin
      pos_r <= child_idx;
    end
    if (cmd.fl_emit) begin
      if (cnt_r == '0) begin
        out_r      <= '0;
        out_ev_r   <= 1'b0;
        out_last_r <= 1'b1;
      end else begin
        out_r      <= rd_a_r;
        out_ev_r   <= 1'b1;
        out_last_r <= sts.fl_last;
        pos_r      <= pos_r + IDX_W'(1);
      end
    end
  end

  assign sts.full      = CMP_W'(cnt_r) >= eff_lim;
  assign sts.cnt_zero  = cnt_r == '0;
  assign sts.pos_zero  = pos_r == '0;
  assign sts.up_less   = $signed(item_r.score) < $signed(rd_a_r.score);
  assign sts.root_less = $signed(rd_a_r.score) < $signed(item_r.score);
  assign sts.dn_move   = pick_l || pick_r;
  assign sts.fl_last   = (CNT_W'(pos_r) + CNT_W'(1)) == cnt_r;
  assign sts.out_free  = !out_valid_r || out_ready;

  assign out_valid        = out_valid_r;
  assign out_entry_score  = out_r.score;
  assign out_entry_source = out_r.source;
  assign out_entry_action = out_r.action;
  assign out_entry_valid  = out_ev_r;
  assign out_last         = out_last_r;

endmodule

/* rtl/beam_top_k_heap_unit.sv */
// Top-k candidate keeper: holds the best beam_limit offers of a round in a binary min-heap
// (root = weakest kept) stored in a two-read, one-write memory with registered reads. Each
// transaction is handled alone. An offer into a heap that is not full is placed at the end
// and rises level by level while it is below its parent. An offer into a full heap is
// compared with the root: it is dropped unless its score is greater, else it replaces the
// root and sinks level by level toward its smaller child. Each level is a memory read
// followed by one compare-and-write step. A flush emits the held entries in memory order,
// or one empty result with last set when the heap is empty, holds while the result side
// stalls, and then empties the heap. beam_limit is to be written only while idle; the
// block itself does not enforce this. 0 acts as 1 and values above capacity saturate.
module beam_top_k_heap_unit import bth_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  bth_in_if.sink           in_ch,
  bth_out_if.source        out_ch,
  input  logic             cfg_we,
  input  logic [LIM_W-1:0] cfg_wdata
);

  cmd_t cmd;
  sts_t sts;

  bth_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_op    (in_ch.op),
    .sts      (sts),
    .in_ready (in_ch.ready),
    .cmd      (cmd)
  );

  bth_datapath u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_we           (cfg_we),
    .cfg_wdata        (cfg_wdata),
    .in_score         (in_ch.score),
    .in_source_index  (in_ch.source_index),
    .in_action_tag    (in_ch.action_tag),
    .cmd              (cmd),
    .sts              (sts),
    .out_valid        (out_ch.valid),
    .out_ready        (out_ch.ready),
    .out_entry_score  (out_ch.entry_score),
    .out_entry_source (out_ch.entry_source),
    .out_entry_action (out_ch.entry_action),
    .out_entry_valid  (out_ch.entry_valid),
    .out_last         (out_ch.last)
  );

endmodule
